// ===== hdl/mepr_pkg.sv =====
// Shared types and constants for the Manchester edge packet receiver.
// Used by the front end, the edge queue, the decoder and the top level.
package mepr_pkg;

  localparam int IntervalW = 10;
  localparam int ExpectW   = 9;
  localparam int CfgIdxW   = 3;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = 2;

  localparam int InDataW  = 16;
  localparam int OutDataW = 24;
  localparam int OutUserW = 2;

  // Offset from the length byte to the total packet length in bytes.
  localparam logic [ExpectW-1:0] LengthOffset = 9'd3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FIRST_START  = 3'd0,
    CFG_SECOND_START = 3'd1,
    CFG_THIRD_START  = 3'd2,
    CFG_FOURTH_START = 3'd3,
    CFG_LONG_PULSE   = 3'd4,
    CFG_TIMEOUT      = 3'd5
  } cfg_idx_t;

  // One edge after classification against the interval registers.
  typedef struct packed {
    logic level;
    logic timeout;
    logic win_first;
    logic win_second;
    logic win_third;
    logic win_fourth;
    logic long_pulse;
  } edge_class_t;

  // Queue status seen by the top level and the decoder.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ===== hdl/mepr_front.sv =====
// Front end: interval registers and edge classification.
// Depends on mepr_pkg for the register indexes and the edge class struct.
module mepr_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [mepr_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [mepr_pkg::IntervalW-1:0]     cfg_data,
  input  logic                               line_level,
  input  logic [mepr_pkg::IntervalW-1:0]     edge_interval,
  output mepr_pkg::edge_class_t              edge_class
);

  logic [mepr_pkg::IntervalW-1:0] first_start;
  logic [mepr_pkg::IntervalW-1:0] second_start;
  logic [mepr_pkg::IntervalW-1:0] third_start;
  logic [mepr_pkg::IntervalW-1:0] fourth_start;
  logic [mepr_pkg::IntervalW-1:0] long_pulse;
  logic [mepr_pkg::IntervalW-1:0] timeout_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_start   <= 10'd80;
      second_start  <= 10'd80;
      third_start   <= 10'd40;
      fourth_start  <= 10'd40;
      long_pulse    <= 10'd20;
      timeout_limit <= 10'd200;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mepr_pkg::CFG_FIRST_START:  first_start   <= cfg_data;
        mepr_pkg::CFG_SECOND_START: second_start  <= cfg_data;
        mepr_pkg::CFG_THIRD_START:  third_start   <= cfg_data;
        mepr_pkg::CFG_FOURTH_START: fourth_start  <= cfg_data;
        mepr_pkg::CFG_LONG_PULSE:   long_pulse    <= cfg_data;
        mepr_pkg::CFG_TIMEOUT:      timeout_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Open window (v, 2v); the doubled bound needs one extra bit.
  function automatic logic in_window(input logic [mepr_pkg::IntervalW-1:0] t,
                                     input logic [mepr_pkg::IntervalW-1:0] v);
    logic [mepr_pkg::IntervalW:0] twice;
    twice = {v, 1'b0};
    return (t > v) && ({1'b0, t} < twice);
  endfunction

  always_comb begin
    edge_class.level      = line_level;
    edge_class.timeout    = edge_interval > timeout_limit;
    edge_class.win_first  = in_window(edge_interval, first_start);
    edge_class.win_second = in_window(edge_interval, second_start);
    edge_class.win_third  = in_window(edge_interval, third_start);
    edge_class.win_fourth = in_window(edge_interval, fourth_start);
    edge_class.long_pulse = edge_interval > long_pulse;
  end

endmodule

// ===== hdl/mepr_queue.sv =====
// Short queue of classified edges between the front end and the decoder.
// Depends on mepr_pkg for the edge class struct and the queue depth.
module mepr_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  mepr_pkg::edge_class_t  push_data,
  input  logic                   pop,
  output mepr_pkg::edge_class_t  head,
  output mepr_pkg::queue_status_t status
);

  mepr_pkg::edge_class_t entries [mepr_pkg::QueueDepth];
  logic [mepr_pkg::QueuePtrW-1:0] wr_ptr;
  logic [mepr_pkg::QueuePtrW-1:0] rd_ptr;
  logic [mepr_pkg::QueuePtrW:0]   fill;

  assign status.full  = fill == (mepr_pkg::QueuePtrW+1)'(mepr_pkg::QueueDepth);
  assign status.empty = fill == '0;
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/mepr_decoder.sv =====
// Back end: start sequence state machine, Manchester bit decoder and the
// output register. Depends on mepr_pkg for the edge class struct.
module mepr_decoder #(
  parameter int MAX_BYTES = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  mepr_pkg::edge_class_t             edge_class,
  input  logic                              edge_avail,
  output logic                              edge_pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_byte_valid,
  output logic [7:0]                        out_data_byte,
  output logic [5:0]                        out_byte_index,
  output logic                              out_packet_done,
  output logic                              out_timed_out,
  output logic [6:0]                        out_packet_length
);

  localparam int CountW = $clog2(MAX_BYTES + 1);
  localparam int CmpW   = (CountW > mepr_pkg::ExpectW) ? CountW : mepr_pkg::ExpectW;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_ARMED  = 3'd1,
    ST_START2 = 3'd2,
    ST_START3 = 3'd3,
    ST_START4 = 3'd4,
    ST_SKIP   = 3'd5,
    ST_DATA   = 3'd6
  } rx_state_t;

  rx_state_t                      state, state_next;
  logic                           odd_phase, odd_phase_next;
  logic [2:0]                     bit_position, bit_position_next;
  logic [7:0]                     byte_shift, byte_shift_next;
  logic [CountW-1:0]              byte_count, byte_count_next;
  logic [mepr_pkg::ExpectW-1:0]   expected_count, expected_count_next;

  logic                           emit;
  logic                           valid;
  logic                           done;
  logic                           tmo;
  logic [7:0]                     data;
  logic [CountW-1:0]              idx;
  logic [CountW-1:0]              plen;
  logic                           take;
  logic [7:0]                     shifted;
  rx_state_t                      s;

  assign edge_pop = edge_avail && (!out_valid || out_ready);

  always_comb begin
    state_next          = state;
    odd_phase_next      = odd_phase;
    bit_position_next   = bit_position;
    byte_shift_next     = byte_shift;
    byte_count_next     = byte_count;
    expected_count_next = expected_count;
    emit  = 1'b0;
    valid = 1'b0;
    done  = 1'b0;
    tmo   = 1'b0;
    data  = '0;
    idx   = '0;
    plen  = '0;
    take  = 1'b0;
    shifted = byte_shift;
    s = state;

    // Timeout or arming on a high idle edge first, then the forced restart on a low edge in the first window.
    if (s != ST_IDLE && edge_class.timeout) begin
      if (s == ST_DATA) begin
        emit = 1'b1;
        done = 1'b1;
        tmo  = 1'b1;
        plen = byte_count;
      end
      s = ST_IDLE;
    end else if (edge_class.level && s == ST_IDLE) begin
      s = ST_ARMED;
    end
    if (!edge_class.level && edge_class.win_first) begin
      s = ST_START2;
    end

    unique case (s)
      ST_START2: begin
        if (edge_class.level) begin
          s = edge_class.win_second ? ST_START3 : ST_IDLE;
        end
      end
      ST_START3: s = edge_class.win_third ? ST_START4 : ST_IDLE;
      ST_START4: s = edge_class.win_fourth ? ST_SKIP : ST_IDLE;
      ST_SKIP: begin
        // The dummy edge after the start sequence clears the byte assembler.
        bit_position_next = '0;
        odd_phase_next    = 1'b0;
        byte_shift_next   = '0;
        byte_count_next   = '0;
        s = ST_DATA;
      end
      ST_DATA: begin
        // A long pulse carries a bit at once; short ones come in pairs, with the bit taken on the later edge.
        take = edge_class.long_pulse || odd_phase;
        odd_phase_next = !edge_class.long_pulse && !odd_phase;
        if (take) begin
          shifted = byte_shift | (8'(edge_class.level) << bit_position);
          if (bit_position == 3'd7) begin
            if (byte_count == '0) begin
              expected_count_next = {1'b0, shifted} + mepr_pkg::LengthOffset;
            end
            if (byte_count < CountW'(MAX_BYTES)) begin
              valid = 1'b1;
              data  = shifted;
              idx   = byte_count;
              byte_count_next = byte_count + 1'b1;
            end
            byte_shift_next   = '0;
            bit_position_next = '0;
          end else begin
            byte_shift_next   = shifted;
            bit_position_next = bit_position + 1'b1;
          end
        end
        emit = valid;
        if (expected_count_next != '0 &&
            CmpW'(byte_count_next) >= CmpW'(expected_count_next)) begin
          emit = 1'b1;
          done = 1'b1;
          plen = byte_count_next;
          byte_count_next = '0;
          s = ST_IDLE;
        end
      end
      default: ;
    endcase
    state_next = s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      odd_phase         <= 1'b0;
      bit_position      <= '0;
      byte_shift        <= '0;
      byte_count        <= '0;
      expected_count    <= '0;
      out_valid         <= 1'b0;
      out_byte_valid    <= 1'b0;
      out_data_byte     <= '0;
      out_byte_index    <= '0;
      out_packet_done   <= 1'b0;
      out_timed_out     <= 1'b0;
      out_packet_length <= '0;
    end else begin
      if (edge_pop) begin
        state             <= state_next;
        odd_phase         <= odd_phase_next;
        bit_position      <= bit_position_next;
        byte_shift        <= byte_shift_next;
        byte_count        <= byte_count_next;
        expected_count    <= expected_count_next;
        out_valid         <= emit;
        out_byte_valid    <= valid;
        out_data_byte     <= data;
        out_byte_index    <= 6'(idx);
        out_packet_done   <= done;
        out_timed_out     <= tmo;
        out_packet_length <= 7'(plen);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/manchester_edge_packet_receiver_top.sv =====
// Top level of the Manchester edge packet receiver.
// Depends on mepr_pkg, mepr_front, mepr_queue and mepr_decoder.
//
// The receiver takes one edge event per input beat: the line level just after
// the edge and the time since the previous edge in 10 us units. A front end
// compares each interval against the six interval registers and pushes the
// resulting edge class into a four-entry queue. The decoder behind the queue
// checks the four-interval start sequence, skips one dummy edge and then
// decodes Manchester data, packing bits least significant first. The first
// byte plus three is the packet length. Every stored byte leaves as one output
// beat with its index; the beat that ends a packet carries tlast and the number
// of bytes stored, and tuser bit 1 marks an end by timeout gap. Bytes beyond
// MAX_BYTES are dropped, so such a packet ends only by timeout. Edges that
// produce no result leave no beat. One input beat is accepted every cycle while
// the queue has room; the decoder retires one queued edge per cycle whenever
// its output register is empty or being read, so throughput is one edge per
// clock while the output is not stalled. An accepted edge is registered in a
// queue entry, and its result then in the decoder's output register. The
// interval registers should be written only while no edge is in flight.
module manchester_edge_packet_receiver_top #(
  parameter int MAX_BYTES = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [mepr_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [mepr_pkg::IntervalW-1:0]     cfg_data,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [0] line_level, [10:1] edge_interval, [15:11] zero
  input  logic [mepr_pkg::InDataW-1:0]       s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [7:0] data_byte, [13:8] byte_index, [20:14] packet_length, [23:21] zero
  output logic [mepr_pkg::OutDataW-1:0]      m_tdata,
  // packet_done
  output logic                               m_tlast,
  // [0] byte_valid, [1] timed_out
  output logic [mepr_pkg::OutUserW-1:0]      m_tuser
);

  mepr_pkg::edge_class_t   in_class;
  mepr_pkg::edge_class_t   head_class;
  mepr_pkg::queue_status_t q_status;
  logic                    push;
  logic                    pop;
  logic                    byte_valid;
  logic [7:0]              data_byte;
  logic [5:0]              byte_index;
  logic                    packet_done;
  logic                    timed_out;
  logic [6:0]              packet_length;

  assign s_tready = !q_status.full;
  assign push     = s_tvalid && s_tready;

  mepr_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .line_level    (s_tdata[0]),
    .edge_interval (s_tdata[mepr_pkg::IntervalW:1]),
    .edge_class    (in_class)
  );

  mepr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (in_class),
    .pop       (pop),
    .head      (head_class),
    .status    (q_status)
  );

  mepr_decoder #(
    .MAX_BYTES (MAX_BYTES)
  ) u_decoder (
    .clk               (clk),
    .rst               (rst),
    .edge_class        (head_class),
    .edge_avail        (!q_status.empty),
    .edge_pop          (pop),
    .out_valid         (m_tvalid),
    .out_ready         (m_tready),
    .out_byte_valid    (byte_valid),
    .out_data_byte     (data_byte),
    .out_byte_index    (byte_index),
    .out_packet_done   (packet_done),
    .out_timed_out     (timed_out),
    .out_packet_length (packet_length)
  );

  assign m_tdata = {3'b000, packet_length, byte_index, data_byte};
  assign m_tlast = packet_done;
  assign m_tuser = {timed_out, byte_valid};

endmodule

// ===== hdl/mepr_checker.sv =====
// Port-level checks for the Manchester edge packet receiver, bound to the top.
// Depends on mepr_pkg for the bus widths.
module mepr_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [mepr_pkg::OutDataW-1:0] m_tdata,
  input logic                          m_tlast,
  input logic [mepr_pkg::OutUserW-1:0] m_tuser
);

  // A stalled output beat holds.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("output beat changed while stalled");

  // Every beat carries a byte, ends a packet, or both.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser[0] || m_tlast)
    else $error("empty output beat");

  // A timeout end never carries a byte and always ends the packet.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tlast && !m_tuser[0])
    else $error("timeout beat malformed");

  // Length is reported only on the last beat; byte fields only with a byte.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast || m_tdata[20:14] == 7'd0) &&
                 (m_tuser[0] || m_tdata[13:0] == 14'd0))
    else $error("stray payload bits");

  // No beat is offered right after reset.
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind manchester_edge_packet_receiver_top mepr_checker u_mepr_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
